// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== rtl/pst_pkg.sv =====
// Types and constants of the pending sequence table.
package pst_pkg;

  localparam int SEQ_W      = 16;
  localparam int TIME_W     = 32;
  localparam int TMO_W      = 16;
  localparam int IN_CTX_W   = 32;
  localparam int OUT_CTX_W  = 32;
  localparam int OUT_CNT_W  = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [TMO_W-1:0] DEFAULT_TIMEOUT = 16'd10;

  // Register index taken from the word address bit.
  localparam logic REG_TIMEOUT = 1'b0;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_TICK = 2'd3;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_EVAL,
    CMD_MARK,
    CMD_SHIFT,
    CMD_CLEAR,
    CMD_APPEND
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic [SEQ_W-1:0]   req_seq;
    logic [TIME_W-1:0]  now;
    logic [TMO_W-1:0]   timeout;
  } cell_ctrl_t;

  typedef struct packed {
    logic               valid;
    logic [SEQ_W-1:0]   seq;
    logic [TIME_W-1:0]  tstamp;
  } entry_t;

  typedef struct packed {
    logic match;
    logic expired;
  } cell_flags_t;

  typedef struct packed {
    logic drop;
    logic shift;
  } cell_sel_t;

endpackage

// ===== rtl/pst_if.sv =====
// Request and result channel interfaces of the pending sequence table.
interface pst_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic [pst_pkg::SEQ_W-1:0]    sequence_req;
  logic [pst_pkg::IN_CTX_W-1:0] context_in;

  modport source (output valid, operation, sequence_req, context_in, input ready);
  modport sink   (input valid, operation, sequence_req, context_in, output ready);
endinterface

interface pst_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [pst_pkg::OUT_CTX_W-1:0] context_out;
  logic                          table_cleared;
  logic [pst_pkg::OUT_CNT_W-1:0] entry_count;

  modport source (output valid, status, context_out, table_cleared, entry_count,
                  input ready);
  modport sink   (input valid, status, context_out, table_cleared, entry_count,
                  output ready);
endinterface

// ===== rtl/pending_sequence_table_with_timeout.sv =====
// Top level of the pending sequence table: request sequencer over a row of cells.
// Paths: tick goes straight to FINISH; insert walks EVAL, DECIDE, APPEND, FINISH,
// with CLEAR before APPEND when a full table is emptied first; a duplicate insert
// ends after DECIDE; lookup and remove walk EVAL, DECIDE, COMPACT (one shift a cycle
// until no hole lies below a kept entry), FINISH. One request is in flight at once.
// Synchronous active-low reset empties the table, zeroes time, sets timeout to 10.
module pending_sequence_table_with_timeout #(
  parameter int CAPACITY      = 16,
  parameter int CONTEXT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pst_in_if.sink                          in_ch,
  pst_out_if.source                       out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pst_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [pst_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [pst_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Sequencer states. Every request but a tick walks EVAL (cells compare in parallel)
  // and DECIDE (ordered resolution over the prefix network), then edits the row.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE,
    S_CLEAR,
    S_APPEND,
    S_COMPACT,
    S_FINISH
  } state_t;

  state_t                             state_r;
  logic [1:0]                         op_r;
  logic [pst_pkg::SEQ_W-1:0]          seq_r;
  logic [CONTEXT_WIDTH-1:0]           ctxin_r;
  logic [pst_pkg::TIME_W-1:0]         now_r;
  logic [pst_pkg::TMO_W-1:0]          timeout_r;
  logic [1:0]                         res_status_r;
  logic [CONTEXT_WIDTH-1:0]           res_ctx_r;
  logic                               res_cleared_r;
  logic                               out_valid_r;
  logic [1:0]                         out_status_r;
  logic [pst_pkg::OUT_CTX_W-1:0]      out_ctx_r;
  logic                               out_cleared_r;
  logic [pst_pkg::OUT_CNT_W-1:0]      out_count_r;

  pst_pkg::cell_ctrl_t                ctrl;
  pst_pkg::entry_t                    ent    [CAPACITY];
  pst_pkg::entry_t                    up_ent [CAPACITY];
  logic [CONTEXT_WIDTH-1:0]           ctx_arr [CAPACITY];
  logic [CONTEXT_WIDTH-1:0]           up_ctx  [CAPACITY];
  logic                               prev_v  [CAPACITY];
  pst_pkg::cell_flags_t               flg    [CAPACITY];
  pst_pkg::cell_sel_t                 sel    [CAPACITY];

  logic [CAPACITY-1:0]                valid_vec;
  logic [CAPACITY-1:0]                match_vec;
  logic [CAPACITY-1:0]                exp_vec;
  logic [CAPACITY-1:0]                hit_vec;
  logic [CAPACITY-1:0]                pfx_in;
  logic [CAPACITY-1:0]                pfx_incl;
  logic [CAPACITY-1:0]                before_vec;
  logic [CAPACITY-1:0]                drop_vec;
  logic [CAPACITY-1:0]                first_hit;
  logic [CAPACITY-1:0]                boundary;
  logic [CONTEXT_WIDTH-1:0]           hit_ctx;
  logic [CNT_W-1:0]                   count;
  logic                               any_set;
  logic                               bubble;
  logic                               cfg_wr;

  logic [CONTEXT_WIDTH+pst_pkg::IN_CTX_W-1:0]  ctx_in_ext;
  logic [CONTEXT_WIDTH+pst_pkg::OUT_CTX_W-1:0] ctx_out_ext;
  logic [CNT_W+pst_pkg::OUT_CNT_W-1:0]         count_ext;

  // Context words are kept at CONTEXT_WIDTH bits and shown on the 32-bit
  // channels through zero extension or truncation.
  assign ctx_in_ext  = {{CONTEXT_WIDTH{1'b0}}, in_ch.context_in};
  assign ctx_out_ext = {{pst_pkg::OUT_CTX_W{1'b0}}, res_ctx_r};
  assign count_ext   = {{pst_pkg::OUT_CNT_W{1'b0}}, count};

  // Configuration port. Only the timeout register exists; a write to any
  // other word is dropped.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == pst_pkg::REG_TIMEOUT) ?
                      {{(pst_pkg::CFG_DATA_W-pst_pkg::TMO_W){1'b0}}, timeout_r} :
                      '0;

  // Flag vectors gathered from the row.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_vec[i] = ent[i].valid;
      match_vec[i] = flg[i].match;
      exp_vec[i]   = flg[i].expired;
      hit_vec[i]   = flg[i].match && !flg[i].expired;
    end
  end

  // The one prefix network serves three questions. While compacting it finds
  // every cell at or above the lowest hole; those cells pull from above. In
  // DECIDE it finds, for each cell, whether a live hit (lookup) or any match
  // (insert, remove) lies below it.
  assign pfx_in = (state_r == S_COMPACT) ? ~valid_vec :
                  ((op_r == pst_pkg::OP_LOOKUP) ? hit_vec : match_vec);

  pst_prefix_or #(.WIDTH(CAPACITY)) u_prefix (
    .x    (pfx_in),
    .incl (pfx_incl)
  );

  assign before_vec = {pfx_incl[CAPACITY-2:0], 1'b0};
  assign any_set    = pfx_incl[CAPACITY-1];
  assign first_hit  = hit_vec & ~before_vec;

  // Lookup drops the expired entries that precede the first live hit; remove
  // drops the first match only.
  assign drop_vec = (op_r == pst_pkg::OP_LOOKUP) ? (exp_vec & ~before_vec) :
                                                   (match_vec & ~before_vec);

  always_comb begin
    hit_ctx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_hit[i]) hit_ctx = hit_ctx | ctx_arr[i];
    end
  end

  // A hole with a live entry above it means compaction is not done. Once the
  // valid bits form a thermometer, the entry count is the top boundary.
  assign bubble   = |(~valid_vec[CAPACITY-2:0] & valid_vec[CAPACITY-1:1]);
  assign boundary = valid_vec & ~{1'b0, valid_vec[CAPACITY-1:1]};

  always_comb begin
    count = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (boundary[i]) count = count | CNT_W'(i + 1);
    end
  end

  // Command broadcast to every cell.
  always_comb begin
    ctrl.req_seq = seq_r;
    ctrl.now     = now_r;
    ctrl.timeout = timeout_r;
    case (state_r)
      S_EVAL:    ctrl.cmd = pst_pkg::CMD_EVAL;
      S_DECIDE:  ctrl.cmd = (op_r inside {pst_pkg::OP_LOOKUP, pst_pkg::OP_REMOVE}) ?
                            pst_pkg::CMD_MARK : pst_pkg::CMD_HOLD;
      S_CLEAR:   ctrl.cmd = pst_pkg::CMD_CLEAR;
      S_APPEND:  ctrl.cmd = pst_pkg::CMD_APPEND;
      S_COMPACT: ctrl.cmd = bubble ? pst_pkg::CMD_SHIFT : pst_pkg::CMD_HOLD;
      default:   ctrl.cmd = pst_pkg::CMD_HOLD;
    endcase
  end

  // The row of cells. Cell 0 is the oldest entry; the top cell pulls an empty
  // slot when the row shifts down.
  genvar g;
  for (g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == CAPACITY - 1) begin : g_top
      assign up_ent[g] = '0;
      assign up_ctx[g] = '0;
    end else begin : g_mid
      assign up_ent[g] = ent[g+1];
      assign up_ctx[g] = ctx_arr[g+1];
    end
    if (g == 0) begin : g_head
      assign prev_v[g] = 1'b1;
    end else begin : g_tail
      assign prev_v[g] = ent[g-1].valid;
    end

    assign sel[g].drop  = drop_vec[g];
    assign sel[g].shift = pfx_incl[g];

    pst_cell #(.CTX_W(CONTEXT_WIDTH)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .load_ctx   (ctxin_r),
      .sel        (sel[g]),
      .prev_valid (prev_v[g]),
      .up_ent     (up_ent[g]),
      .up_ctx     (up_ctx[g]),
      .ent        (ent[g]),
      .ctx        (ctx_arr[g]),
      .flags      (flg[g])
    );
  end

  // Sequencer, time base, timeout register and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      now_r       <= '0;
      timeout_r   <= pst_pkg::DEFAULT_TIMEOUT;
    end else begin
      if (cfg_wr && cfg_paddr[2] == pst_pkg::REG_TIMEOUT) begin
        timeout_r <= cfg_pwdata[pst_pkg::TMO_W-1:0];
      end
      // In FINISH a result taken this cycle is replaced by the next one below.
      if (out_valid_r && out_ch.ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r          <= in_ch.operation;
            seq_r         <= in_ch.sequence_req;
            ctxin_r       <= ctx_in_ext[CONTEXT_WIDTH-1:0];
            res_ctx_r     <= '0;
            res_cleared_r <= 1'b0;
            if (in_ch.operation == pst_pkg::OP_TICK) begin
              now_r        <= now_r + 1'b1;
              res_status_r <= pst_pkg::ST_TICK;
              state_r      <= S_FINISH;
            end else begin
              res_status_r <= pst_pkg::ST_OK;
              state_r      <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          case (op_r)
            pst_pkg::OP_INSERT: begin
              // A full table is emptied first, so the new entry cannot be a
              // duplicate of anything left behind.
              if (valid_vec[CAPACITY-1]) begin
                res_cleared_r <= 1'b1;
                state_r       <= S_CLEAR;
              end else if (any_set) begin
                res_status_r <= pst_pkg::ST_DUP;
                state_r      <= S_FINISH;
              end else begin
                state_r <= S_APPEND;
              end
            end
            pst_pkg::OP_LOOKUP: begin
              res_status_r <= any_set ? pst_pkg::ST_OK : pst_pkg::ST_MISS;
              res_ctx_r    <= hit_ctx;
              state_r      <= S_COMPACT;
            end
            pst_pkg::OP_REMOVE: begin
              res_status_r <= any_set ? pst_pkg::ST_OK : pst_pkg::ST_MISS;
              state_r      <= S_COMPACT;
            end
            default: begin
              state_r <= S_FINISH;
            end
          endcase
        end
        S_CLEAR: begin
          state_r <= S_APPEND;
        end
        S_APPEND: begin
          state_r <= S_FINISH;
        end
        S_COMPACT: begin
          if (!bubble) state_r <= S_FINISH;
        end
        S_FINISH: begin
          // The result register may still hold the previous result; wait
          // until it has been taken.
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= res_status_r;
            out_ctx_r     <= ctx_out_ext[pst_pkg::OUT_CTX_W-1:0];
            out_cleared_r <= res_cleared_r;
            out_count_r   <= count_ext[pst_pkg::OUT_CNT_W-1:0];
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.context_out   = out_ctx_r;
  assign out_ch.table_cleared = out_cleared_r;
  assign out_ch.entry_count   = out_count_r;

endmodule

// ===== rtl/pst_prefix_or.sv =====
// Log-depth inclusive prefix OR across the row of table cells.
module pst_prefix_or #(
  parameter int WIDTH = 16
) (
  input  logic [WIDTH-1:0] x,
  output logic [WIDTH-1:0] incl
);

  localparam int LVLS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] lvl [LVLS+1];

  always_comb begin
    lvl[0] = x;
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (i >= (1 << l)) begin
          lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
        end else begin
          lvl[l+1][i] = lvl[l][i];
        end
      end
    end
  end

  assign incl = lvl[LVLS];

endmodule

// ===== rtl/pst_cell.sv =====
// One slot of the table: holds an entry and trades it with the cell above.
module pst_cell #(
  parameter int CTX_W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pst_pkg::cell_ctrl_t  ctrl,
  input  logic [CTX_W-1:0]     load_ctx,
  input  pst_pkg::cell_sel_t   sel,
  input  logic                 prev_valid,
  input  pst_pkg::entry_t      up_ent,
  input  logic [CTX_W-1:0]     up_ctx,
  output pst_pkg::entry_t      ent,
  output logic [CTX_W-1:0]     ctx,
  output pst_pkg::cell_flags_t flags
);

  logic                          valid_r;
  logic [pst_pkg::SEQ_W-1:0]     seq_r;
  logic [pst_pkg::TIME_W-1:0]    tstamp_r;
  logic [CTX_W-1:0]              ctx_r;
  pst_pkg::cell_flags_t          flags_r;
  logic [pst_pkg::TIME_W-1:0]    age;
  logic                          append_here;

  assign age         = ctrl.now - tstamp_r;
  assign append_here = !valid_r && prev_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (ctrl.cmd)
        pst_pkg::CMD_MARK:   if (sel.drop)   valid_r <= 1'b0;
        pst_pkg::CMD_SHIFT:  if (sel.shift)  valid_r <= up_ent.valid;
        pst_pkg::CMD_CLEAR:  valid_r <= 1'b0;
        pst_pkg::CMD_APPEND: if (append_here) valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      pst_pkg::CMD_EVAL: begin
        flags_r.match   <= valid_r && (seq_r == ctrl.req_seq);
        flags_r.expired <= valid_r &&
                           (age >= {{(pst_pkg::TIME_W-pst_pkg::TMO_W){1'b0}}, ctrl.timeout});
      end
      pst_pkg::CMD_SHIFT: begin
        if (sel.shift) begin
          seq_r    <= up_ent.seq;
          tstamp_r <= up_ent.tstamp;
          ctx_r    <= up_ctx;
        end
      end
      pst_pkg::CMD_APPEND: begin
        if (append_here) begin
          seq_r    <= ctrl.req_seq;
          tstamp_r <= ctrl.now;
          ctx_r    <= load_ctx;
        end
      end
      default: ;
    endcase
  end

  assign ent.valid  = valid_r;
  assign ent.seq    = seq_r;
  assign ent.tstamp = tstamp_r;
  assign ctx        = ctx_r;
  assign flags      = flags_r;

endmodule

// ===== rtl/pst_checker.sv =====
// Port-level checker for the pending sequence table, with its bind.
`include "assert_macros.svh"

module pst_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_status,
  input logic [pst_pkg::OUT_CTX_W-1:0] out_context,
  input logic                          out_cleared,
  input logic [pst_pkg::OUT_CNT_W-1:0] out_count
);

  logic [pst_pkg::OUT_CTX_W+1:0] out_data;
  logic                          clear_result_ok;
  logic                          fail_result_quiet;

  assign out_data          = {out_status, out_context};
  assign clear_result_ok   = (out_status == pst_pkg::ST_OK) && (out_count == 5'd1);
  assign fail_result_quiet = (out_context == '0) && !out_cleared;

  // Only one request is in flight: taking one closes the input side.
  `ASSERT_NEXT(a_one_request, clk, rst_n, in_valid && in_ready, !in_ready)

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // Emptying a full table is always followed by a successful append.
  `ASSERT_IMPL(a_cleared_ok, clk, rst_n, out_valid && out_cleared, clear_result_ok)

  // Only a lookup hit carries a context, and only an insert clears.
  `ASSERT_IMPL(a_quiet_fail, clk, rst_n, out_valid && out_status != pst_pkg::ST_OK, fail_result_quiet)

endmodule

bind pending_sequence_table_with_timeout pst_checker u_pst_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_context (out_ch.context_out),
  .out_cleared (out_ch.table_cleared),
  .out_count   (out_ch.entry_count)
);
